### design/psd_pkg.sv
// Shared types and constants for the polyline spacing decimator.
`timescale 1ns / 1ps

package psd_pkg;

    localparam int SPACING_BITS = 24;
    localparam int SUM_BITS     = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int KIND_BITS    = 2;

    localparam logic [SPACING_BITS-1:0] SPACING_RESET = 24'd102;

    // What the back end does with a queued point
    typedef enum logic [KIND_BITS-1:0] {
        KIND_START    = 2'd0,
        KIND_SINGLE   = 2'd1,
        KIND_INTERIOR = 2'd2,
        KIND_FINAL    = 2'd3
    } psd_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_SQR,
        ST_LOAD,
        ST_ROOT,
        ST_DECIDE,
        ST_EMIT
    } psd_state_t;

endpackage

### design/psd_queue.sv
// Small register queue between the front and the back of the decimator.
`timescale 1ns / 1ps

module psd_queue #(
    parameter int WIDTH = 74,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                push, pop;

    assign in_ready  = (count_reg != CNT_BITS'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### design/psd_front.sv
// Input side: tracks the open line and classifies each point for the back end.
`timescale 1ns / 1ps

module psd_front
    import psd_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [3*COORD_BITS-1:0] in_point,
    input  logic                    in_first,
    input  logic                    in_final,
    output logic                    q_valid,
    input  logic                    q_ready,
    output psd_kind_t               q_kind,
    output logic [3*COORD_BITS-1:0] q_point
);

    logic line_open_reg, line_open_next;
    logic accept;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign q_point  = in_point;
    assign accept   = in_valid && q_ready;

    // Any point with no line open starts a new line
    always_comb begin
        if (in_first || !line_open_reg) begin
            q_kind = in_final ? KIND_SINGLE : KIND_START;
        end else begin
            q_kind = in_final ? KIND_FINAL : KIND_INTERIOR;
        end
    end

    always_comb begin
        line_open_next = line_open_reg;
        if (accept) begin
            line_open_next = !in_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_open_reg <= 1'b0;
        end else begin
            line_open_reg <= line_open_next;
        end
    end

endmodule

### design/psd_back.sv
// Back end: distance to the anchor, spacing decision and the output register.
`timescale 1ns / 1ps

module psd_back
    import psd_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [SPACING_BITS-1:0]   min_spacing,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  psd_kind_t                 q_kind,
    input  logic [3*COORD_BITS-1:0]   q_point,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [3*COORD_BITS-1:0]   out_point,
    output logic                      out_last
);

    localparam int C      = COORD_BITS;
    localparam int PT_W   = 3 * C;
    localparam int RES_W  = PT_W + 1;
    localparam int PROD_W = 2 * C;
    localparam int ACC_W  = 2 * C + 2;
    localparam int RAD_W  = (ACC_W > 64) ? 64 : ACC_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int CMP_W  = SUM_BITS + 1;

    psd_state_t state_reg, state_next;

    logic [PT_W-1:0]   anchor_reg;
    logic [PT_W-1:0]   cur_reg;
    psd_kind_t         kind_reg;
    logic [SUM_BITS-1:0] sum_reg;
    logic [C-1:0]      mag_reg [3];
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RES_W-1:0]  res0_reg, res1_reg;
    logic              res_two_reg;
    logic              res_idx_reg;
    logic              out_valid_reg;
    logic [RES_W-1:0]  out_reg;

    logic              out_free, out_load, pop;
    logic [RAD_W-1:0]  rad_sat;
    logic [C-1:0]      mag_sel;
    logic [REM_W-1:0]  rem_shift, trial;
    logic              fits;
    logic [CMP_W-1:0]  sum_wide;
    logic [SUM_BITS-1:0] sum_new;
    logic [CMP_W-1:0]  dist_wide, min_wide;
    logic              sum_reached, dist_reached;

    // Magnitude of a signed coordinate difference
    function automatic logic [C-1:0] axis_mag(input logic [C-1:0] a, input logic [C-1:0] b);
        logic [C:0] diff;
        logic [C:0] neg;
        diff = {a[C-1], a} - {b[C-1], b};
        neg  = -diff;
        return diff[C] ? neg[C-1:0] : diff[C-1:0];
    endfunction

    generate
        if (ACC_W > RAD_W) begin : g_sat
            assign rad_sat = (|acc_reg[ACC_W-1:RAD_W]) ? '1 : acc_reg[RAD_W-1:0];
        end else begin : g_nosat
            assign rad_sat = acc_reg;
        end
    endgenerate

    assign mag_sel   = mag_reg[cnt_reg[1:0]];
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    assign dist_wide    = CMP_W'(root_reg);
    assign min_wide     = CMP_W'(min_spacing);
    assign sum_wide     = {1'b0, sum_reg} + dist_wide;
    assign sum_new      = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
    assign sum_reached  = (CMP_W'(sum_new) >= min_wide);
    assign dist_reached = (dist_wide >= min_wide);

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_point = out_reg[PT_W-1:0];
    assign out_last  = out_reg[PT_W];

    // Handshake outputs of the sequencer
    always_comb begin
        pop      = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop      = q_valid;
            ST_EMIT: out_load = out_free;
            default: begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign q_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_kind)
                        KIND_START:  state_next = ST_IDLE;
                        KIND_SINGLE: state_next = ST_EMIT;
                        default:     state_next = ST_MAG;
                    endcase
                end
            end
            ST_MAG: state_next = ST_SQR;
            ST_SQR: begin
                if (cnt_reg == CNT_W'(3)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_ROOT;
            ST_ROOT: begin
                if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (kind_reg == KIND_INTERIOR && !sum_reached) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && !(res_two_reg && !res_idx_reg)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res_idx_reg ? res1_reg : res0_reg;
        end
        unique case (state_reg)
            ST_IDLE: begin
                res_idx_reg <= 1'b0;
                if (pop) begin
                    kind_reg <= q_kind;
                    cur_reg  <= q_point;
                    if (q_kind == KIND_START || q_kind == KIND_SINGLE) begin
                        anchor_reg <= q_point;
                        sum_reg    <= '0;
                    end
                    // Single-point line: distance zero against itself
                    if (q_kind == KIND_SINGLE) begin
                        res_two_reg <= (min_spacing == '0);
                        res0_reg    <= {(min_spacing != '0), q_point};
                        res1_reg    <= {1'b1, q_point};
                    end
                end
            end
            ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= axis_mag(cur_reg[i*C +: C], anchor_reg[i*C +: C]);
                end
                cnt_reg <= '0;
            end
            ST_SQR: begin
                if (cnt_reg != CNT_W'(3)) begin
                    prod_reg <= {{C{1'b0}}, mag_sel} * {{C{1'b0}}, mag_sel};
                end
                if (cnt_reg == CNT_W'(1)) begin
                    acc_reg <= ACC_W'(prod_reg);
                end else if (cnt_reg != '0) begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_LOAD: begin
                rad_reg  <= rad_sat;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_ROOT: begin
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                if (fits) begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_DECIDE: begin
                if (kind_reg == KIND_INTERIOR) begin
                    // Emit the pending anchor and advance it once the sum reaches the spacing
                    if (sum_reached) begin
                        res0_reg    <= {1'b0, anchor_reg};
                        res_two_reg <= 1'b0;
                        anchor_reg  <= cur_reg;
                        sum_reg     <= '0;
                    end else begin
                        sum_reg <= sum_new;
                    end
                end else begin
                    // Final point: replace the pending point when too close
                    sum_reg <= '0;
                    if (dist_reached) begin
                        res0_reg    <= {1'b0, anchor_reg};
                        res1_reg    <= {1'b1, cur_reg};
                        res_two_reg <= 1'b1;
                    end else begin
                        res0_reg    <= {1'b1, cur_reg};
                        res_two_reg <= 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    res_idx_reg <= 1'b1;
                end
            end
            default: begin
                res_idx_reg <= 1'b0;
            end
        endcase
    end

endmodule

### design/polyline_spacing_decimator.sv
// Polyline spacing decimator: top level with config register, front, queue and back.
//
// Usage: points of a polyline stream in on the s_ channel, one word per point,
// s_tuser marking the first point and s_tlast the last. Kept points leave on the
// m_ channel, m_tlast marking the last kept point of the line. The minimum
// spacing is written on the cfg_ channel (always ready); the user writes it only
// while the block is idle, which the block itself does not enforce.
// Sequencing: the back end takes a new word only in its idle state. An interior
// or final point holds the back end through these steps in order: take the word,
// form the axis differences, form the three squares through one multiplier, load
// the root, run a square root that settles one result bit per cycle, and decide;
// each kept word it emits then waits for the output register to be free. A first
// point only sets the anchor; a single-point line is emitted once, or twice when
// the minimum spacing is zero. A kept word reaches m_ through the queue and the
// output register. A two-entry queue lets the input side take words while the
// back end works on an earlier one.
// When the receiver stalls, the output word holds in its register and the back
// end waits; the queue fills and then s_tready drops. Reset clears the open line,
// empties the queue and output, and sets the minimum spacing to 102.
`timescale 1ns / 1ps

module polyline_spacing_decimator
    import psd_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // pos_x, pos_y, pos_z from bit 0 up, zero padded to whole bytes
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // first_point
    input  logic                                   s_tuser,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_x, out_y, out_z from bit 0 up, zero padded to whole bytes
    output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    output logic                                   m_tlast,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [SPACING_BITS-1:0]                cfg_data
);

    localparam int PT_W    = 3 * COORD_BITS;
    localparam int TDATA_W = ((PT_W + 7) / 8) * 8;
    localparam int ENTRY_W = KIND_BITS + PT_W;

    logic [SPACING_BITS-1:0] min_spacing_reg;

    logic              fq_valid, fq_ready;
    psd_kind_t         fq_kind;
    logic [PT_W-1:0]   fq_point;
    logic              qb_valid, qb_ready;
    logic [ENTRY_W-1:0] qb_entry;
    logic [PT_W-1:0]   out_point;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_spacing_reg <= SPACING_RESET;
        end else if (cfg_valid) begin
            min_spacing_reg <= cfg_data;
        end
    end

    psd_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_point (s_tdata[PT_W-1:0]),
        .in_first (s_tuser),
        .in_final (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_kind   (fq_kind),
        .q_point  (fq_point)
    );

    psd_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_kind, fq_point}),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_entry)
    );

    psd_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .min_spacing (min_spacing_reg),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_kind      (psd_kind_t'(qb_entry[ENTRY_W-1 -: KIND_BITS])),
        .q_point     (qb_entry[PT_W-1:0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_point   (out_point),
        .out_last    (m_tlast)
    );

    assign m_tdata = TDATA_W'(out_point);

endmodule
